### sv/ist_pkg.sv
// shared opcodes and sizing constants for the id set table
package ist_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int PID_W           = 32;
  localparam int OP_W            = 3;

  localparam logic [OP_W-1:0] OP_QUERY     = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_ROOT  = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_CHILD = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

endpackage

### sv/id_set_table_with_child_inherit.sv
// top level: id set table with scan sequencer and result register
//
// A bounded set of 32-bit ids held in one two-port memory. Each beat on
// the command side (start high while busy is low) carries one operation; the
// block then scans the members one memory read per cycle, comparing each
// against pid and parent_pid, decides, writes back at most one entry and
// emits one result beat on done for exactly one cycle. Done is registered
// from the decide state, or from a move state for a remove that hits,
// since that remove needs a second read of the last member before moving
// it into the freed slot. busy stays high from the accepting edge until
// the result is shown, so a new command can be given in the cycle the
// result appears. The receiver cannot stall: done is a strobe and the
// result fields are valid only while it is high. The store needs no
// clearing after reset, since only slots below the count are read.
module id_set_table_with_child_inherit #(
  parameter int MAX_ENTRIES = ist_pkg::MAX_ENTRIES_DEF,
  parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ist_pkg::OP_W-1:0]  op,
  input  logic [ist_pkg::PID_W-1:0] pid,
  input  logic [ist_pkg::PID_W-1:0] parent_pid,
  output logic                      busy,
  output logic                      done,
  output logic                      hit,
  output logic                      changed,
  output logic [CW-1:0]             member_count
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_MOVE   = 2'd3;

  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  logic [1:0]                 state;
  // latched command beat
  logic [ist_pkg::OP_W-1:0]   cur_op;
  logic [ist_pkg::PID_W-1:0]  cur_pid;
  logic [ist_pkg::PID_W-1:0]  cur_parent;
  // scan bookkeeping
  logic [CW-1:0]              issue;
  logic                       pend;
  logic [AW-1:0]              cmp_idx;
  logic                       found;
  logic                       par_found;
  logic [AW-1:0]              slot;
  logic [CW-1:0]              used_count;

  // memory port
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [ist_pkg::PID_W-1:0]  rd_data;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [ist_pkg::PID_W-1:0]  wr_data;

  // decision outcome
  logic                       emit;
  logic                       emit_changed;
  logic [CW-1:0]              count_new;
  logic                       go_move;
  logic                       scan_more;

  assign busy      = (state != S_IDLE);
  assign scan_more = (issue < used_count);

  ist_mem #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = issue[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = cur_pid;
    emit         = 1'b0;
    emit_changed = 1'b0;
    count_new    = used_count;
    go_move      = 1'b0;
    case (state)
      S_SCAN: begin
        rd_en = scan_more;
      end
      S_DECIDE: begin
        emit = 1'b1;
        case (cur_op)
          ist_pkg::OP_SET_ROOT: begin
            if (cur_pid != '0) begin
              // unchanged only when the set already was exactly {pid}
              emit_changed = !((used_count == CNT_ONE) && found);
              wr_en        = 1'b1;
              count_new    = CNT_ONE;
            end else begin
              emit_changed = (used_count != '0);
              count_new    = '0;
            end
          end
          ist_pkg::OP_CLEAR: begin
            emit_changed = (used_count != '0);
            count_new    = '0;
          end
          ist_pkg::OP_ADD_CHILD: begin
            if (par_found && !found && (used_count < CNT_MAX)) begin
              wr_en        = 1'b1;
              wr_addr      = used_count[AW-1:0];
              emit_changed = 1'b1;
              count_new    = used_count + CNT_ONE;
            end
          end
          ist_pkg::OP_REMOVE: begin
            if (found) begin
              // fetch the last member, it fills the freed slot next cycle
              rd_en   = 1'b1;
              rd_addr = AW'(used_count - CNT_ONE);
              go_move = 1'b1;
              emit    = 1'b0;
            end
          end
          default: begin
            // query and unused opcodes leave the table alone
          end
        endcase
      end
      S_MOVE: begin
        wr_en        = 1'b1;
        wr_addr      = slot;
        wr_data      = rd_data;
        emit         = 1'b1;
        emit_changed = 1'b1;
        count_new    = used_count - CNT_ONE;
      end
      default: begin
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used_count   <= '0;
      done         <= 1'b0;
      issue        <= '0;
      pend         <= 1'b0;
      cmp_idx      <= '0;
      found        <= 1'b0;
      par_found    <= 1'b0;
    end else begin
      done <= emit;
      if (emit) begin
        hit          <= found;
        changed      <= emit_changed;
        member_count <= count_new;
        used_count   <= count_new;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur_op     <= op;
            cur_pid    <= pid;
            cur_parent <= parent_pid;
            issue      <= '0;
            pend       <= 1'b0;
            cmp_idx    <= '0;
            found      <= 1'b0;
            par_found  <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_more) begin
            issue <= issue + CNT_ONE;
          end
          pend <= scan_more;
          if (pend) begin
            // first match wins for the slot, any match counts for the parent
            if ((rd_data == cur_pid) && !found) begin
              found <= 1'b1;
              slot  <= cmp_idx;
            end
            if (rd_data == cur_parent) begin
              par_found <= 1'b1;
            end
            cmp_idx <= cmp_idx + AW'(1);
          end
          if (!scan_more && !pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= go_move ? S_MOVE : S_IDLE;
        end
        S_MOVE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result beat only follows a decide or move cycle
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_DECIDE || $past(state) == S_MOVE))
    else $error("result beat without a decision");

  // count never passes the table size
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_MAX)
    else $error("member count beyond table size");

  // memory is written only while deciding or moving
  a_wr_phase: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_DECIDE || state == S_MOVE))
    else $error("store written outside write-back");

  // an accepted command keeps the block busy the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // a changing remove shrinks the count by exactly one
  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |=> (used_count == $past(used_count) - CNT_ONE))
    else $error("remove did not drop count by one");

endmodule

### sv/ist_mem.sv
// synchronous id store, one read and one write per cycle, registered read
module ist_mem #(
  parameter int MAX_ENTRIES = ist_pkg::MAX_ENTRIES_DEF,
  parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [ist_pkg::PID_W-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [ist_pkg::PID_W-1:0] wr_data
);

  logic [ist_pkg::PID_W-1:0] store [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

### bench/id_set_table_with_child_inherit_tb.sv
// testbench for the id set table: directed and random commands against a shadow set
module id_set_table_with_child_inherit_tb;

  localparam int ENTRIES = ist_pkg::MAX_ENTRIES_DEF;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  typedef logic [ist_pkg::OP_W-1:0]  op_code_t;
  typedef logic [ist_pkg::PID_W-1:0] pid_t;

  // opcodes the block treats as a plain lookup
  localparam op_code_t OP_RSVD_A = 3'd5;
  localparam op_code_t OP_RSVD_B = 3'd6;
  localparam op_code_t OP_RSVD_C = 3'd7;

  // gaps between commands, in percent of cycles the sender stays idle
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_HEAVY = 84;
  localparam int IDLE_LIGHT = 22;
  localparam int MAX_GAP    = 60;

  // ceiling on the whole run
  localparam int RUN_LIMIT = 10_000_000;

  typedef struct packed {
    logic             hit;
    logic             changed;
    logic [CNT_W-1:0] count;
  } set_result_t;

  logic              clk;
  logic              rst;
  logic              start;
  op_code_t          op;
  pid_t              pid;
  pid_t              parent_pid;
  logic              busy;
  logic              done;
  logic              hit;
  logic              changed;
  logic [CNT_W-1:0]  member_count;

  // shadow copy of the set: only entries below member_total are members
  pid_t              member_ids [ENTRIES];
  int unsigned       member_total;

  // results still owed by the block, oldest first
  set_result_t       pending_results [$];
  int                fail_count;
  int                idle_pct;

  id_set_table_with_child_inherit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .pid          (pid),
    .parent_pid   (parent_pid),
    .busy         (busy),
    .done         (done),
    .hit          (hit),
    .changed      (changed),
    .member_count (member_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // first member slot holding id, or -1 when id is not in the set
  function automatic int find_member(input pid_t id);
    for (int i = 0; i < member_total; i++) begin
      if (member_ids[i] == id) return i;
    end
    return -1;
  endfunction

  // apply one command to the shadow set and return the result the block owes
  function automatic set_result_t apply_membership_cmd(input op_code_t cmd,
                                                       input pid_t id,
                                                       input pid_t parent);
    set_result_t r;
    int          slot;
    slot      = find_member(id);
    r.hit     = (slot >= 0);
    r.changed = 1'b0;
    case (cmd)
      ist_pkg::OP_SET_ROOT: begin
        if (id != '0) begin
          // unchanged only when the set already was exactly this id
          r.changed     = !(member_total == 1 && member_ids[0] == id);
          member_ids[0] = id;
          member_total  = 1;
        end else begin
          r.changed    = (member_total != 0);
          member_total = 0;
        end
      end
      ist_pkg::OP_CLEAR: begin
        r.changed    = (member_total != 0);
        member_total = 0;
      end
      ist_pkg::OP_ADD_CHILD: begin
        // parent must be present, child absent, and a free slot left
        if (find_member(parent) >= 0 && slot < 0 && member_total < ENTRIES) begin
          member_ids[member_total] = id;
          member_total++;
          r.changed = 1'b1;
        end
      end
      ist_pkg::OP_REMOVE: begin
        // last member moves into the freed slot so the set stays packed
        if (slot >= 0) begin
          member_ids[slot] = member_ids[member_total - 1];
          member_total--;
          r.changed = 1'b1;
        end
      end
      default: begin
        // lookup and the reserved opcodes leave the set alone
      end
    endcase
    r.count = member_total[CNT_W-1:0];
    return r;
  endfunction

  // any current member, or a random id when the set is empty
  function automatic pid_t some_member();
    if (member_total == 0) return $urandom;
    return member_ids[$urandom_range(member_total - 1)];
  endfunction

  // one command beat: optional idle gap, then start held until busy is low
  task automatic send_cmd(input op_code_t cmd, input pid_t id, input pid_t parent);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      // idle cycles carry junk on the payload, which must be ignored
      start      = 1'b0;
      op         = op_code_t'($urandom);
      pid        = $urandom;
      parent_pid = $urandom;
      repeat (gap) @(negedge clk);
    end
    start      = 1'b1;
    op         = cmd;
    pid        = id;
    parent_pid = parent;
    // the beat is taken at the first rising edge that sees busy low
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_membership_cmd(cmd, id, parent));
  endtask

  // every result beat is checked against the oldest owed result
  always @(posedge clk) begin
    set_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding: hit %0b changed %0b count %0d",
               hit, changed, member_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, hit);
          fail_count++;
        end
        if (changed !== want.changed) begin
          $error("changed: expected %0b, got %0b", want.changed, changed);
          fail_count++;
        end
        if (member_count !== want.count) begin
          $error("member_count: expected %0d, got %0d", want.count, member_count);
          fail_count++;
        end
      end
    end
  end

  // lookups, removes, clears, a zero root and a refused add on a set that is still empty
  task automatic test_empty_set();
    send_cmd(ist_pkg::OP_QUERY, '0, '0);
    send_cmd(ist_pkg::OP_QUERY, '1, '1);
    send_cmd(ist_pkg::OP_REMOVE, 32'h0000_1234, '0);
    send_cmd(ist_pkg::OP_CLEAR, 32'h0000_0042, '0);
    send_cmd(ist_pkg::OP_SET_ROOT, '0, '1);
    // parent absent, even a zero parent, so the add is refused
    send_cmd(ist_pkg::OP_ADD_CHILD, 32'h0000_0005, '0);
  endtask

  // roots, inherited children and their refusals, removal of the first slot, zero roots and clears
  task automatic test_root_and_children();
    send_cmd(ist_pkg::OP_SET_ROOT, '1, '0);
    // same root again: set already exactly that id
    send_cmd(ist_pkg::OP_SET_ROOT, '1, 32'h1357_9bdf);
    send_cmd(ist_pkg::OP_ADD_CHILD, '0, '1);
    send_cmd(ist_pkg::OP_ADD_CHILD, 32'h8000_0001, '0);
    // child already present
    send_cmd(ist_pkg::OP_ADD_CHILD, '0, '0);
    // parent not a member
    send_cmd(ist_pkg::OP_ADD_CHILD, 32'h7fff_fffe, 32'h0000_dead);
    send_cmd(ist_pkg::OP_QUERY, 32'h8000_0001, '0);
    send_cmd(ist_pkg::OP_REMOVE, '1, '0);
    send_cmd(ist_pkg::OP_REMOVE, 32'h0bad_0bad, '0);
    send_cmd(ist_pkg::OP_QUERY, '1, '0);
    // zero root on a non-empty set empties it, then again on an empty one
    send_cmd(ist_pkg::OP_SET_ROOT, '0, '0);
    send_cmd(ist_pkg::OP_SET_ROOT, '0, '0);
    send_cmd(ist_pkg::OP_SET_ROOT, 32'ha5a5_a5a5, '0);
    send_cmd(ist_pkg::OP_CLEAR, 32'ha5a5_a5a5, '0);
    send_cmd(ist_pkg::OP_CLEAR, '0, '0);
  endtask

  // reserved opcodes only report membership
  task automatic test_reserved_ops();
    send_cmd(ist_pkg::OP_SET_ROOT, 32'h0000_0001, '0);
    send_cmd(OP_RSVD_A, 32'h0000_0001, 32'h0000_0001);
    send_cmd(OP_RSVD_B, 32'h0000_0002, 32'h0000_0001);
    send_cmd(OP_RSVD_C, 32'h0000_0001, '1);
  endtask

  // grow the set to capacity, hit the full refusal, then churn near the top
  task automatic test_fill_to_capacity();
    pid_t victim;
    send_cmd(ist_pkg::OP_SET_ROOT, $urandom | 32'h1, '0);
    while (member_total < ENTRIES) send_cmd(ist_pkg::OP_ADD_CHILD, $urandom, some_member());
    send_cmd(ist_pkg::OP_ADD_CHILD, $urandom, some_member());
    send_cmd(ist_pkg::OP_QUERY, member_ids[ENTRIES - 1], '0);
    send_cmd(ist_pkg::OP_REMOVE, member_ids[ENTRIES - 1], '0);
    victim = member_ids[ENTRIES / 2];
    send_cmd(ist_pkg::OP_REMOVE, victim, '0);
    send_cmd(ist_pkg::OP_QUERY, victim, '0);
    send_cmd(ist_pkg::OP_ADD_CHILD, victim, some_member());
    send_cmd(ist_pkg::OP_ADD_CHILD, $urandom, some_member());
    send_cmd(ist_pkg::OP_ADD_CHILD, $urandom, some_member());
    send_cmd(ist_pkg::OP_CLEAR, '0, '0);
  endtask

  // mostly well-formed family trees with random ids, some noise mixed in
  task automatic test_random_ops(input int n_items, input int pct);
    int       pick;
    op_code_t cmd;
    pid_t     id;
    pid_t     parent;
    idle_pct = pct;
    for (int k = 0; k < n_items; k++) begin
      pick   = $urandom_range(99);
      id     = $urandom;
      parent = $urandom;
      if (member_total == 0 && pick < 70) begin
        cmd = ist_pkg::OP_SET_ROOT;
      end else if (pick < 48) begin
        cmd = ist_pkg::OP_ADD_CHILD;
        if ($urandom_range(99) < 85) parent = some_member();
        case ($urandom_range(9))
          0: id = some_member();
          1: id = '0;
          default: ;
        endcase
      end else if (pick < 68) begin
        cmd = ist_pkg::OP_REMOVE;
        if ($urandom_range(99) < 80) id = some_member();
      end else if (pick < 88) begin
        cmd = ist_pkg::OP_QUERY;
        if ($urandom_range(99) < 60) id = some_member();
      end else if (pick < 92) begin
        cmd = ist_pkg::OP_SET_ROOT;
        case ($urandom_range(3))
          0: id = '0;
          1: id = some_member();
          default: ;
        endcase
      end else if (pick < 95) begin
        cmd = ist_pkg::OP_CLEAR;
      end else begin
        // any opcode at all, reserved ones included
        cmd = op_code_t'($urandom_range(7));
        if ($urandom_range(1)) id = some_member();
      end
      send_cmd(cmd, id, parent);
    end
  endtask

  initial begin
    int waited;
    rst          = 1'b1;
    start        = 1'b0;
    op           = ist_pkg::OP_QUERY;
    pid          = '0;
    parent_pid   = '0;
    member_total = 0;
    fail_count   = 0;
    idle_pct     = IDLE_NONE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_set();
    test_root_and_children();
    test_reserved_ops();
    test_fill_to_capacity();
    test_random_ops(600, IDLE_NONE);
    test_random_ops(575, IDLE_HEAVY);
    test_random_ops(575, IDLE_LIGHT);

    @(negedge clk);
    start = 1'b0;
    // drain: the slowest result is a full scan plus its decision and move
    waited = 0;
    while (pending_results.size() != 0 && waited < 20 * ENTRIES) begin
      @(posedge clk);
      waited++;
    end
    repeat (ENTRIES + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #RUN_LIMIT;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
